FILE: rtl/ipm_pkg.sv
package ipm_pkg;

    localparam int COEF_W     = 32;
    localparam int COORD_W    = 16;
    localparam int PROD_W     = COEF_W + COORD_W + 1;
    localparam int SUM_W      = PROD_W + 1;
    localparam int NMAG_W     = SUM_W - 1;
    localparam int DMAG_W     = SUM_W - 2;
    localparam int FRAC_W     = 16;
    localparam int OUT_W      = 32;
    localparam int QUOT_W     = OUT_W + 1;
    localparam int CONST_SH   = 4;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_X_U     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_X_V     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_CONST = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_U     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_Y_V     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_CONST = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_W_V     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_W_CONST = 3'd7;

    localparam logic [OUT_W-1:0] OUT_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_HORIZON = 2'd1,
        ST_SAT     = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COEF_W-1:0] x_u;
        logic signed [COEF_W-1:0] x_v;
        logic signed [COEF_W-1:0] x_const;
        logic signed [COEF_W-1:0] y_u;
        logic signed [COEF_W-1:0] y_v;
        logic signed [COEF_W-1:0] y_const;
        logic signed [COEF_W-1:0] w_v;
        logic signed [COEF_W-1:0] w_const;
    } t_coefs;

    typedef struct packed {
        logic signed [SUM_W-1:0] nx;
        logic signed [SUM_W-1:0] ny;
        logic signed [SUM_W-1:0] w;
    } t_sums;

    // Signed Q8.24 coefficient times unsigned Q12.4 coordinate, exact in Q.28.
    function automatic logic signed [PROD_W-1:0] mul_coef(
        input logic signed [COEF_W-1:0] coef,
        input logic [COORD_W-1:0]       coord
    );
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = PROD_W'(coef);
        b = PROD_W'($signed({1'b0, coord}));
        return a * b;
    endfunction

    // Constant term brought to Q.28 by a factor of sixteen.
    function automatic logic signed [SUM_W-1:0] const_term(
        input logic signed [COEF_W-1:0] coef
    );
        logic signed [SUM_W-1:0] e;
        e = SUM_W'(coef);
        return e <<< CONST_SH;
    endfunction

endpackage

FILE: rtl/ipm_regs.sv
module ipm_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ipm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ipm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ipm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output ipm_pkg::t_coefs                 o_coefs
);
    import ipm_pkg::*;

    t_coefs                 r_coefs;
    logic [REG_IDX_W-1:0]   w_idx;
    logic                   w_wr;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_coefs = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_X_U:     r_coefs.x_u     <= pwdata;
                REG_X_V:     r_coefs.x_v     <= pwdata;
                REG_X_CONST: r_coefs.x_const <= pwdata;
                REG_Y_U:     r_coefs.y_u     <= pwdata;
                REG_Y_V:     r_coefs.y_v     <= pwdata;
                REG_Y_CONST: r_coefs.y_const <= pwdata;
                REG_W_V:     r_coefs.w_v     <= pwdata;
                REG_W_CONST: r_coefs.w_const <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_X_U:     prdata = r_coefs.x_u;
            REG_X_V:     prdata = r_coefs.x_v;
            REG_X_CONST: prdata = r_coefs.x_const;
            REG_Y_U:     prdata = r_coefs.y_u;
            REG_Y_V:     prdata = r_coefs.y_v;
            REG_Y_CONST: prdata = r_coefs.y_const;
            REG_W_V:     prdata = r_coefs.w_v;
            REG_W_CONST: prdata = r_coefs.w_const;
        endcase
    end

endmodule

FILE: rtl/ipm_mac.sv
module ipm_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ipm_pkg::COORD_W-1:0]     i_u_coord,
    input  logic [ipm_pkg::COORD_W-1:0]     i_v_coord,
    input  ipm_pkg::t_coefs                 i_coefs,
    output logic                            o_valid,
    input  logic                            i_ready,
    output ipm_pkg::t_sums                  o_sums
);
    import ipm_pkg::*;

    // Product stage.
    logic                       r_pv;
    logic signed [PROD_W-1:0]   r_pxu, r_pxv, r_pyu, r_pyv, r_pwv;
    // Sum stage.
    logic                       r_sv;
    t_sums                      r_sums;
    t_sums                      n_sums;
    logic                       w_acc_p, w_acc_s;

    assign w_acc_s = !r_sv || i_ready;
    assign w_acc_p = !r_pv || w_acc_s;
    assign o_ready = w_acc_p;
    assign o_valid = r_sv;
    assign o_sums  = r_sums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (w_acc_p) r_pv <= i_valid;
            if (w_acc_s) r_sv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_p) begin
            r_pxu <= mul_coef(i_coefs.x_u, i_u_coord);
            r_pxv <= mul_coef(i_coefs.x_v, i_v_coord);
            r_pyu <= mul_coef(i_coefs.y_u, i_u_coord);
            r_pyv <= mul_coef(i_coefs.y_v, i_v_coord);
            r_pwv <= mul_coef(i_coefs.w_v, i_v_coord);
        end
    end

    // The user must hold the coefficients still while requests are in flight; the block does
    // not enforce it, and takes the constant terms straight from the registers here.
    always_comb begin
        n_sums.nx = SUM_W'(r_pxu) + SUM_W'(r_pxv) + const_term(i_coefs.x_const);
        n_sums.ny = SUM_W'(r_pyu) + SUM_W'(r_pyv) + const_term(i_coefs.y_const);
        n_sums.w  = SUM_W'(r_pwv) + const_term(i_coefs.w_const);
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_s) r_sums <= n_sums;
    end

endmodule

FILE: rtl/ipm_div.sv
module ipm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  ipm_pkg::t_sums                  i_sums,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [ipm_pkg::OUT_W-1:0]       o_ground_x,
    output logic [ipm_pkg::OUT_W-1:0]       o_ground_y,
    output ipm_pkg::t_status                o_status
);
    import ipm_pkg::*;

    localparam int NDIV   = QUOT_W + 1;
    localparam int HI_LSB = QUOT_W - FRAC_W;

    typedef struct packed {
        logic [NMAG_W-1:0] nx;
        logic [NMAG_W-1:0] ny;
        logic [DMAG_W-1:0] d;
        logic              negx;
        logic              negy;
        logic              hor;
    } t_mag;

    typedef struct packed {
        logic [DMAG_W-1:0] p;
        logic [QUOT_W-1:0] q;
    } t_pq;

    typedef struct packed {
        t_pq               x;
        t_pq               y;
        logic [DMAG_W-1:0] d;
        logic              ovfx;
        logic              ovfy;
        logic              negx;
        logic              negy;
        logic              hor;
    } t_dstage;

    typedef struct packed {
        logic              sat;
        logic [OUT_W-1:0]  val;
    } t_res;

    function automatic logic [SUM_W-1:0] abs_val(input logic signed [SUM_W-1:0] a);
        return a[SUM_W-1] ? SUM_W'(-a) : SUM_W'(a);
    endfunction

    // The partial remainder starts from the numerator bits above the quotient
    // window; the rest, with sixteen zero fraction bits, waits in q.
    function automatic t_pq div_init(input logic [NMAG_W-1:0] n);
        t_pq r;
        r.p = DMAG_W'(n[NMAG_W-1:HI_LSB]);
        r.q = {n[HI_LSB-1:0], {FRAC_W{1'b0}}};
        return r;
    endfunction

    function automatic t_pq div_bit(input t_pq a, input logic [DMAG_W-1:0] d);
        logic [DMAG_W:0] t;
        t_pq             r;
        t = {a.p, a.q[QUOT_W-1]};
        if (t >= {1'b0, d}) begin
            r.p = DMAG_W'(t - {1'b0, d});
            r.q = {a.q[QUOT_W-2:0], 1'b1};
        end else begin
            r.p = t[DMAG_W-1:0];
            r.q = {a.q[QUOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_dstage first_stage(input t_mag m);
        t_dstage s;
        s.x    = div_init(m.nx);
        s.y    = div_init(m.ny);
        s.d    = m.d;
        s.ovfx = DMAG_W'(m.nx[NMAG_W-1:HI_LSB]) >= m.d;
        s.ovfy = DMAG_W'(m.ny[NMAG_W-1:HI_LSB]) >= m.d;
        s.negx = m.negx;
        s.negy = m.negy;
        s.hor  = m.hor;
        return s;
    endfunction

    function automatic t_dstage next_stage(input t_dstage a);
        t_dstage s;
        s   = a;
        s.x = div_bit(a.x, a.d);
        s.y = div_bit(a.y, a.d);
        return s;
    endfunction

    function automatic t_res clamp(input logic [QUOT_W-1:0] q, input logic neg,
                                   input logic ovf);
        t_res r;
        if (neg) begin
            r.sat = ovf || q[QUOT_W-1] || (q[OUT_W-1] && (|q[OUT_W-2:0]));
        end else begin
            r.sat = ovf || q[QUOT_W-1] || q[OUT_W-1];
        end
        if (r.sat) begin
            r.val = neg ? OUT_NEG_MAX : OUT_POS_MAX;
        end else if (neg) begin
            r.val = ~q[OUT_W-1:0] + {{(OUT_W-1){1'b0}}, 1'b1};
        end else begin
            r.val = q[OUT_W-1:0];
        end
        return r;
    endfunction

    logic               r_mv;
    t_mag               r_mag;
    t_mag               n_mag;
    logic               r_sv [NDIV];
    t_dstage            r_st [NDIV];
    logic               w_acc [NDIV];
    logic               w_acc_m, w_acc_o;
    logic               r_out_v;
    logic [OUT_W-1:0]   r_gx, r_gy;
    t_status            r_status;
    t_res               n_rx, n_ry;

    assign w_acc_o = !r_out_v || i_ready;
    assign w_acc_m = !r_mv || w_acc[0];
    assign o_ready = w_acc_m;

    // Magnitude and sign stage.
    always_comb begin
        n_mag.nx   = NMAG_W'(abs_val(i_sums.nx));
        n_mag.ny   = NMAG_W'(abs_val(i_sums.ny));
        n_mag.d    = DMAG_W'(abs_val(i_sums.w));
        n_mag.negx = i_sums.nx[SUM_W-1] ^ i_sums.w[SUM_W-1];
        n_mag.negy = i_sums.ny[SUM_W-1] ^ i_sums.w[SUM_W-1];
        n_mag.hor  = (i_sums.w == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (w_acc_m) begin
            r_mv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_m) r_mag <= n_mag;
    end

    // One quotient bit per stage after the first, which sets up the remainder and checks for overflow.
    for (genvar k = 0; k < NDIV; k++) begin : g_stage
        if (k == NDIV - 1) begin : g_last_acc
            assign w_acc[k] = !r_sv[k] || w_acc_o;
        end else begin : g_acc
            assign w_acc[k] = !r_sv[k] || w_acc[k+1];
        end

        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[k] <= 1'b0;
                end else if (w_acc[k]) begin
                    r_sv[k] <= r_mv;
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_acc[k]) r_st[k] <= first_stage(r_mag);
            end
        end else begin : g_bit
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[k] <= 1'b0;
                end else if (w_acc[k]) begin
                    r_sv[k] <= r_sv[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_acc[k]) r_st[k] <= next_stage(r_st[k-1]);
            end
        end
    end

    // Saturation, sign and horizon handling into the output register.
    always_comb begin
        n_rx = clamp(r_st[NDIV-1].x.q, r_st[NDIV-1].negx, r_st[NDIV-1].ovfx);
        n_ry = clamp(r_st[NDIV-1].y.q, r_st[NDIV-1].negy, r_st[NDIV-1].ovfy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_acc_o) begin
            r_out_v <= r_sv[NDIV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_o) begin
            if (r_st[NDIV-1].hor) begin
                r_gx     <= '0;
                r_gy     <= '0;
                r_status <= ST_HORIZON;
            end else begin
                r_gx     <= n_rx.val;
                r_gy     <= n_ry.val;
                r_status <= (n_rx.sat || n_ry.sat) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_valid    = r_out_v;
    assign o_ground_x = r_gx;
    assign o_ground_y = r_gy;
    assign o_status   = r_status;

endmodule

FILE: rtl/image_to_ground_projection.sv
// Throughput: one request per clock unless the output side holds off; the pipeline has two
// multiply-add stages, one magnitude stage, an overflow stage and 33 one-bit divider stages,
// then the output register. Reset (synchronous, active low) empties every stage and clears
// all eight coefficients, so every request after reset reports the horizon status until
// software loads them.
module image_to_ground_projection (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ipm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ipm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ipm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ipm_pkg::COORD_W-1:0]     i_u_coord,
    input  logic [ipm_pkg::COORD_W-1:0]     i_v_coord,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [ipm_pkg::OUT_W-1:0] o_ground_x,
    output logic signed [ipm_pkg::OUT_W-1:0] o_ground_y,
    output logic [1:0]                      o_status
);
    import ipm_pkg::*;

    // The block holds no state of its own between requests. The coefficient
    // registers form the homogeneous projection:
    //   w = w_v*v + w_const, x = (x_u*u + x_v*v + x_const)/w,
    //   y = (y_u*u + y_v*v + y_const)/w.
    // Coordinates are unsigned Q12.4, coefficients signed Q8.24, so every
    // product is exact in Q.28; the constant terms are scaled up by sixteen to
    // match. The quotients are signed Q16.16, truncated towards zero.
    //
    // Every stage carries its own valid bit and may advance whenever the stage
    // after it is empty or moving, so bubbles close up and a new request is
    // taken while a finished result still waits at the output register.

    t_coefs             w_coefs;
    t_sums              w_sums;
    logic               w_sums_valid;
    logic               w_sums_ready;
    t_status            w_status;
    logic [OUT_W-1:0]   w_gx, w_gy;

    // APB register file; reads are answered in the access cycle.
    ipm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (w_coefs)
    );

    // Five coefficient-by-coordinate products, then the three sums.
    ipm_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_u_coord (i_u_coord),
        .i_v_coord (i_v_coord),
        .i_coefs   (w_coefs),
        .o_valid   (w_sums_valid),
        .i_ready   (w_sums_ready),
        .o_sums    (w_sums)
    );

    // Both quotients run side by side through one pipelined restoring divider, bit by bit from
    // the most significant, with saturation and sign applied at the end.
    ipm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_sums_valid),
        .o_ready    (w_sums_ready),
        .i_sums     (w_sums),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_ground_x (w_gx),
        .o_ground_y (w_gy),
        .o_status   (w_status)
    );

    assign o_ground_x = w_gx;
    assign o_ground_y = w_gy;
    assign o_status   = w_status;

`ifndef SYNTHESIS
    // The input can only be held off when every stage is full, which means
    // the output register is occupied and its request is not being taken.
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input held off while the output side is free");

    a_horizon_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_HORIZON)) |-> ((o_ground_x == '0) && (o_ground_y == '0)))
        else $error("horizon result with non-zero coordinates");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_SAT)) |->
        ((o_ground_x == OUT_POS_MAX) || (o_ground_x == OUT_NEG_MAX) ||
         (o_ground_y == OUT_POS_MAX) || (o_ground_y == OUT_NEG_MAX)))
        else $error("saturated status without a clamped coordinate");
`endif

endmodule

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipm_pkg::*;

    // One expected ground point, in the order the requests were accepted.
    typedef struct {
        logic [OUT_W-1:0] x;
        logic [OUT_W-1:0] y;
        t_status          status;
    } t_ground_point;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [COORD_W-1:0]      i_u_coord;
    logic [COORD_W-1:0]      i_v_coord;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [OUT_W-1:0] o_ground_x;
    logic signed [OUT_W-1:0] o_ground_y;
    logic [1:0]              o_status;

    // The testbench's own copy of the eight coefficient registers.
    logic signed [COEF_W-1:0] coef_regs [8];

    t_ground_point expected_points [$];
    int            mismatch_count = 0;

    // Idling controls. The sender draws a random gap before every request and
    // the receiver a random stall after every result, while the corresponding
    // switch is on. A long hold-off overrides the receiver.
    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    int rx_stall_left   = 0;
    int rx_hold_cycles  = 0;

    image_to_ground_projection u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_u_coord   (i_u_coord),
        .i_v_coord   (i_v_coord),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ground_x  (o_ground_x),
        .o_ground_y  (o_ground_y),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A generous ceiling on the run time.
    initial begin
        #1ms;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Signed quotient num/den in Q16.16, truncated toward zero and clamped.
    // The magnitudes are divided at 128 bits so that the sixteen fraction
    // bits never overflow, whatever the size of the numerator.
    function automatic logic [OUT_W-1:0] divide_q16(input longint num, input longint den,
                                                    inout bit sat);
        logic [127:0] n_mag;
        logic [127:0] d_mag;
        logic [127:0] q;
        bit           neg;
        n_mag = (num < 0) ? 128'(-num) : 128'(num);
        d_mag = (den < 0) ? 128'(-den) : 128'(den);
        neg   = (num < 0) != (den < 0);
        q     = (n_mag << FRAC_W) / d_mag;
        if (!neg) begin
            if (q > 128'(OUT_POS_MAX)) begin
                sat = 1'b1;
                return OUT_POS_MAX;
            end
            return q[OUT_W-1:0];
        end
        // A negative result may reach exactly -2^31 without clamping.
        if (q > 128'(OUT_NEG_MAX)) begin
            sat = 1'b1;
            return OUT_NEG_MAX;
        end
        return {OUT_W{1'b0}} - q[OUT_W-1:0];
    endfunction

    // Projects one image point onto the ground plane with the current
    // coefficients. Products are exact in Q.28; constants are scaled by 16.
    function automatic t_ground_point project_point(input logic [COORD_W-1:0] u,
                                                    input logic [COORD_W-1:0] v);
        longint        lu;
        longint        lv;
        longint        den;
        longint        num_x;
        longint        num_y;
        bit            sat;
        t_ground_point p;
        lu    = {48'd0, u};
        lv    = {48'd0, v};
        den   = coef_regs[REG_W_V] * lv + coef_regs[REG_W_CONST] * 64'sd16;
        num_x = coef_regs[REG_X_U] * lu + coef_regs[REG_X_V] * lv
              + coef_regs[REG_X_CONST] * 64'sd16;
        num_y = coef_regs[REG_Y_U] * lu + coef_regs[REG_Y_V] * lv
              + coef_regs[REG_Y_CONST] * 64'sd16;
        sat   = 1'b0;
        if (den == 0) begin
            // The point lies on the horizon: no ground intersection.
            p.x      = '0;
            p.y      = '0;
            p.status = ST_HORIZON;
            return p;
        end
        p.x      = divide_q16(num_x, den, sat);
        p.y      = divide_q16(num_y, den, sat);
        p.status = sat ? ST_SAT : ST_OK;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Both handshakes are sampled at the rising edge. The output side is
    // checked first; the request accepted at the same edge is then predicted.
    always @(posedge i_clk) begin
        t_ground_point want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                rx_stall_left = receiver_stalls ? $urandom_range(0, 3) : 0;
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending: x=%h y=%h st=%0d",
                                              o_ground_x, o_ground_y, o_status));
                end else begin
                    want = expected_points.pop_front();
                    if (o_ground_x !== want.x) begin
                        report_mismatch($sformatf("ground_x got %h expected %h",
                                                  o_ground_x, want.x));
                    end
                    if (o_ground_y !== want.y) begin
                        report_mismatch($sformatf("ground_y got %h expected %h",
                                                  o_ground_y, want.y));
                    end
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("status got %0d expected %s",
                                                  o_status, want.status.name()));
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_points.push_back(project_point(i_u_coord, i_v_coord));
            end
        end
    end

    // The receiver: ready is driven at the falling edge, low during a long
    // hold-off or a per-result stall, high otherwise.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                i_out_ready <= 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    task automatic write_coef(input logic [REG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        coef_regs[idx] = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reads a register back and compares it with the local copy.
    task automatic check_coef(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DATA_W-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== coef_regs[idx]) begin
            report_mismatch($sformatf("register %0d read %h expected %h",
                                      idx, got, coef_regs[idx]));
        end
    endtask

    // A coefficient biased towards the interesting values: zero, both
    // extremes, full-range noise and moderate camera-like magnitudes.
    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3, 4, 5: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_random_coefs();
        for (int i = 0; i < 8; i++) begin
            write_coef(REG_IDX_W'(i), pick_coef());
        end
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request after a random gap and returns once it has been
    // accepted. Valid is left high so that the next request can follow at once.
    task automatic send_point(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_u_coord  <= u;
        i_v_coord  <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stops offering requests and waits until every prediction has been met,
    // which leaves the block idle for register writes.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // With every coefficient cleared by reset, the registers read back as zero and each point lies on the horizon.
    task automatic test_reset_horizon();
        for (int i = 0; i < 8; i++) begin
            check_coef(REG_IDX_W'(i));
        end
        send_point(16'h0000, 16'h0000);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h1234, 16'hFFFF);
        wait_drained();
    endtask

    // Every register is written with a distinct pattern and read back, then
    // the sign-bit extremes are tried, alternating from register to register.
    task automatic test_register_access();
        for (int i = 0; i < 8; i++) begin
            write_coef(REG_IDX_W'(i), 32'h1357_9BDF ^ (i * 32'h1111_1111));
        end
        for (int i = 0; i < 8; i++) begin
            check_coef(REG_IDX_W'(i));
        end
        for (int i = 0; i < 8; i++) begin
            write_coef(REG_IDX_W'(i), (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
            check_coef(REG_IDX_W'(i));
        end
    endtask

    // A camera-like set-up whose horizon lies at row 100 (1600 in Q12.4).
    // Rows above it give a negative denominator, rows below a positive one.
    task automatic test_camera_geometry();
        write_coef(REG_X_U,     32'h0001_0000);
        write_coef(REG_X_V,     32'h0000_0000);
        write_coef(REG_X_CONST, 32'hFF00_0000);
        write_coef(REG_Y_U,     32'h0000_0000);
        write_coef(REG_Y_V,     32'h0002_0000);
        write_coef(REG_Y_CONST, 32'h0400_0000);
        write_coef(REG_W_V,     32'h0100_0000);
        write_coef(REG_W_CONST, 32'h9C00_0000);
        send_point(16'd0,     16'd0);
        send_point(16'hFFFF,  16'hFFFF);
        send_point(16'd5120,  16'd1600);
        send_point(16'd5120,  16'd1601);
        send_point(16'd5120,  16'd1599);
        send_point(16'h8000,  16'h8000);
        wait_drained();
    endtask

    // Constant-only numerators over a denominator of 16 (one step of w_const) put
    // outputs on, just past or just inside the limits of Q16.16, or at zero.
    task automatic test_saturation_limits();
        write_coef(REG_X_U,     '0);
        write_coef(REG_X_V,     '0);
        write_coef(REG_Y_U,     '0);
        write_coef(REG_Y_V,     '0);
        write_coef(REG_W_V,     '0);
        write_coef(REG_W_CONST, 32'd1);
        // x just over the positive limit, y exactly at the negative limit.
        write_coef(REG_X_CONST, 32'd32768);
        write_coef(REG_Y_CONST, -32'sd32768);
        send_point(16'd7, 16'd9);
        wait_drained();
        // x the largest exact value, y just over the negative limit.
        write_coef(REG_X_CONST, 32'd32767);
        write_coef(REG_Y_CONST, -32'sd32769);
        send_point(16'hFFFF, 16'h0000);
        wait_drained();
        // x exactly at the negative limit and a zero numerator for y.
        write_coef(REG_X_CONST, -32'sd32768);
        write_coef(REG_Y_CONST, '0);
        send_point(16'h0000, 16'hFFFF);
        wait_drained();
    endtask

    task automatic test_coefficient_extremes();
        for (int i = 0; i < 8; i++) begin
            write_coef(REG_IDX_W'(i), 32'h7FFF_FFFF);
        end
        send_point(16'h0000, 16'h0000);
        send_point(16'hFFFF, 16'hFFFF);
        wait_drained();
        for (int i = 0; i < 8; i++) begin
            write_coef(REG_IDX_W'(i), 32'h8000_0000);
        end
        send_point(16'hFFFF, 16'h0000);
        send_point(16'h0000, 16'hFFFF);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while requests keep coming
    // back to back, so the pipeline fills and input ready must fall. After
    // that the sender pauses for a full drain before each of two further bursts.
    task automatic test_backpressure();
        load_random_coefs();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b1;
        rx_hold_cycles  = 400;
        for (int n = 0; n < 200; n++) begin
            send_point(16'($urandom), 16'($urandom));
        end
        wait_drained();
        sender_gaps = 1'b1;
        for (int n = 0; n < 40; n++) begin
            send_point(16'($urandom), 16'($urandom));
        end
        wait_drained();
        for (int n = 0; n < 40; n++) begin
            send_point(pick_coord(), pick_coord());
        end
        wait_drained();
    endtask

    // Twelve settings of a hundred requests each. Some settings place the
    // horizon on a chosen row and aim about a quarter of the requests at it.
    task automatic test_random_projection();
        int                 scale;
        logic [COORD_W-1:0] horizon_row;
        bit                 aim_horizon;
        for (int phase = 0; phase < 12; phase++) begin
            wait_drained();
            load_random_coefs();
            aim_horizon = (phase % 5 == 2);
            if (aim_horizon) begin
                // w = 16*scale*(v - horizon_row), zero exactly on that row.
                scale       = $urandom_range(1, 32767);
                scale       = $urandom_range(0, 1) ? -scale : scale;
                horizon_row = 16'($urandom);
                write_coef(REG_W_V,     32'(scale * 16));
                write_coef(REG_W_CONST, 32'(-scale * int'(horizon_row)));
            end
            sender_gaps     = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 100; n++) begin
                if (aim_horizon && $urandom_range(0, 3) == 0) begin
                    send_point(pick_coord(), horizon_row);
                end else begin
                    send_point(pick_coord(), pick_coord());
                end
            end
        end
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n    = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        i_in_valid = 1'b0;
        i_u_coord  = '0;
        i_v_coord  = '0;
        for (int i = 0; i < 8; i++) begin
            coef_regs[i] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_horizon();
        test_register_access();
        test_camera_geometry();
        test_saturation_limits();
        test_coefficient_extremes();
        test_backpressure();
        test_random_projection();

        // Let any stray result surface after the last expected one.
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (expected_points.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_points.size()));
        end
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
